// ----- rtl/core/bmp24_pkg.sv -----
// shared types and constants for the 24-bit bmp stream decoder
`default_nettype none

package bmp24_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  error_code;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
    } t_result;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_MAGIC      = 3'd1;
    localparam logic [2:0] ERR_PLANES     = 3'd2;
    localparam logic [2:0] ERR_DEPTH      = 3'd3;
    localparam logic [2:0] ERR_COMPRESSED = 3'd4;
    localparam logic [2:0] ERR_OFFSET     = 3'd5;
    localparam logic [2:0] ERR_SIZE       = 3'd6;

    localparam logic [15:0] MAGIC_BM     = 16'h4D42;
    localparam logic [15:0] PLANE_COUNT  = 16'd1;
    localparam logic [15:0] PIXEL_DEPTH  = 16'd24;
    localparam logic [31:0] HEADER_BYTES = 32'd34;

endpackage

`default_nettype wire

// ----- rtl/core/bmp24_in_reg.sv -----
// input word register with stall toward the upstream side
`default_nettype none

module bmp24_in_reg
    import bmp24_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  wire   i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bmp24_parse.sv -----
// header parser, offset skip and pixel assembly with the decoder state
`default_nettype none

module bmp24_parse
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_fire,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    localparam logic [31:0] POS_MAGIC  = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_PLANES = 32'd27;
    localparam logic [31:0] POS_DEPTH  = 32'd29;
    localparam logic [31:0] POS_LAST   = 32'd33;

    logic [2:0]  r_phase,  n_phase;
    logic [31:0] r_pos,    n_pos;
    logic [31:0] r_acc,    n_acc;
    logic [12:0] r_width,  n_width;
    logic [12:0] r_height, n_height;
    logic [31:0] r_offset, n_offset;
    logic [11:0] r_col,    n_col;
    logic [11:0] r_row,    n_row;
    logic [1:0]  r_comp,   n_comp;
    logic [7:0]  r_blue,   n_blue;
    logic [7:0]  r_green,  n_green;
    logic [1:0]  r_pad,    n_pad;

    logic       row_end;
    logic       last;
    logic [7:0] b;

    assign b = i_item.data_byte;

    always_comb begin
        if (i_item.start_of_file) begin
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_acc    = '0;
            n_width  = '0;
            n_height = '0;
            n_offset = '0;
            n_col    = '0;
            n_row    = '0;
            n_comp   = '0;
            n_blue   = '0;
            n_green  = '0;
            n_pad    = '0;
        end else begin
            n_phase  = r_phase;
            n_pos    = r_pos;
            n_acc    = r_acc;
            n_width  = r_width;
            n_height = r_height;
            n_offset = r_offset;
            n_col    = r_col;
            n_row    = r_row;
            n_comp   = r_comp;
            n_blue   = r_blue;
            n_green  = r_green;
            n_pad    = r_pad;
        end

        o_res_valid = 1'b0;
        o_res       = '0;

        row_end = ({1'b0, n_col} + 13'd1) >= n_width;
        last    = row_end && (({1'b0, n_row} + 13'd1) >= n_height);

        unique case (n_phase)
            PH_HEADER: begin
                n_acc = {b, n_acc[31:8]};
                if (n_pos == POS_MAGIC) begin
                    if (n_acc[31:16] != MAGIC_BM) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_MAGIC;
                        n_phase          = PH_IDLE;
                    end
                end else if (n_pos == POS_OFFSET) begin
                    n_offset = n_acc;
                end else if (n_pos == POS_WIDTH) begin
                    n_width = (n_acc == '0 || n_acc > 32'(MAX_WIDTH)) ? '0 : n_acc[12:0];
                end else if (n_pos == POS_HEIGHT) begin
                    n_height = (n_acc == '0 || n_acc > 32'(MAX_HEIGHT)) ? '0 : n_acc[12:0];
                end else if (n_pos == POS_PLANES) begin
                    if (n_acc[31:16] != PLANE_COUNT) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_PLANES;
                        n_phase          = PH_IDLE;
                    end
                end else if (n_pos == POS_DEPTH) begin
                    if (n_acc[31:16] != PIXEL_DEPTH) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_DEPTH;
                        n_phase          = PH_IDLE;
                    end
                end else if (n_pos == POS_LAST) begin
                    if (n_acc != '0) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_COMPRESSED;
                        n_phase          = PH_IDLE;
                    end else if (n_offset < HEADER_BYTES) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_OFFSET;
                        n_phase          = PH_IDLE;
                    end else if (n_width == '0 || n_height == '0) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_SIZE;
                        n_phase          = PH_IDLE;
                    end else begin
                        n_row = '0;
                        n_pad = '0;
                        if (n_offset == HEADER_BYTES) begin
                            n_col   = '0;
                            n_comp  = '0;
                            n_phase = PH_PIXEL;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                n_pos = n_pos + 32'd1;
            end
            PH_SKIP: begin
                n_pos = n_pos + 32'd1;
                if (n_pos == n_offset) begin
                    n_col   = '0;
                    n_comp  = '0;
                    n_phase = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                if (n_comp == 2'd0) begin
                    n_blue = b;
                    n_comp = 2'd1;
                end else if (n_comp == 2'd1) begin
                    n_green = b;
                    n_comp  = 2'd2;
                end else begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_PIXEL;
                    o_res.error_code = ERR_NONE;
                    o_res.column     = n_col;
                    o_res.row        = 12'(n_height - 13'd1 - {1'b0, n_row});
                    o_res.red        = b;
                    o_res.green      = n_green;
                    o_res.blue       = n_blue;
                    o_res.last_pixel = last;
                    n_comp           = 2'd0;
                    if (last) begin
                        n_phase = PH_IDLE;
                    end else if (row_end) begin
                        n_row = n_row + 12'd1;
                        n_col = '0;
                        n_pad = n_width[1:0];
                        n_phase = (n_width[1:0] != 2'd0) ? PH_PAD : PH_PIXEL;
                    end else begin
                        n_col = n_col + 12'd1;
                    end
                end
            end
            PH_PAD: begin
                n_pad = n_pad - 2'd1;
                if (n_pad == 2'd0) begin
                    n_col   = '0;
                    n_comp  = '0;
                    n_phase = PH_PIXEL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_offset <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_comp   <= '0;
            r_blue   <= '0;
            r_green  <= '0;
            r_pad    <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_offset <= n_offset;
            r_col    <= n_col;
            r_row    <= n_row;
            r_comp   <= n_comp;
            r_blue   <= n_blue;
            r_green  <= n_green;
            r_pad    <= n_pad;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bmp24_out_reg.sv -----
// result register toward the downstream side
`default_nettype none

module bmp24_out_reg
    import bmp24_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_res_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_word,
    input  wire     i_stall
);

    logic    r_valid;
    t_result r_word;

    assign o_ready = !(r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_word <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bmp_24bit_stream_decoder.sv -----
// top level of the 24-bit bmp stream decoder
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_in_word  (byte, start of file)
//   output    out        o_out_valid / i_out_stall o_out_word (pixel or error)
//
// one byte per clock while no stall holds the flow; a taken byte's result enters the result register when it is ready
// the per-byte work is one pass through the parser between input and result registers
// at most one result per byte; skipped bytes, padding and header bytes without an error give none
// reset is synchronous, active low, and clears all control and parser state
// a stalled result holds while at most one more byte is taken into the input register
`default_nettype none

module bmp_24bit_stream_decoder
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  t_item   i_in_word,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_out_word,
    input  wire     i_out_stall
);

    logic    item_valid;
    t_item   item;
    logic    ready;
    logic    res_valid;
    t_result res;

    bmp24_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_word),
        .o_stall (o_in_stall),
        .i_take  (ready),
        .o_valid (item_valid),
        .o_item  (item)
    );

    bmp24_parse #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (item_valid && ready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bmp24_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid && item_valid),
        .i_res       (res),
        .o_ready     (ready),
        .o_valid     (o_out_valid),
        .o_word      (o_out_word),
        .i_stall     (i_out_stall)
    );

endmodule

`default_nettype wire
